// File: hw/rtl/pgm_pkg.sv
package pgm_pkg;

  localparam int PatternMax = 32;
  localparam int NPos       = PatternMax + 1;
  localparam int IdxW       = $clog2(PatternMax);
  localparam int CntW       = $clog2(PatternMax + 1);
  localparam int QDepth     = 2;
  localparam int QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW      = $clog2(QDepth + 1);
  localparam int CfgIdxW    = 1;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 8;

  localparam logic [CfgIdxW-1:0] CfgSearchMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCaseFold   = 1'b1;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] CaseDiff = 8'h20;

  typedef enum logic [1:0] {
    KindLit   = 2'd0,
    KindQmark = 2'd1,
    KindStar  = 2'd2,
    KindGlob  = 2'd3
  } tok_kind_e;

  typedef struct packed {
    logic search_mode;
    logic case_fold;
  } cfg_t;

  typedef struct packed {
    logic       is_path;
    logic [7:0] chr;
    logic       present;
    logic       first;
    logic       last;
    tok_kind_e  cls;
    logic       sep;
  } item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

  // Epsilon closure of the active set: a set bit runs through a chain of
  // star tokens like a carry through propagate bits.
  function automatic logic [NPos-1:0] closure_f(input logic [NPos-1:0] a,
                                                input logic [PatternMax-1:0] p,
                                                input logic seed);
    logic [NPos-1:0]       a0;
    logic [NPos-1:0]       sum;
    logic [NPos-1:0]       carry;
    logic [PatternMax-1:0] g;
    a0    = a | NPos'(seed);
    g     = a0[PatternMax-1:0] & p;
    sum   = {1'b0, p} + {1'b0, g};
    carry = sum ^ {1'b0, p} ^ {1'b0, g};
    return a0 | carry;
  endfunction

endpackage

// File: hw/rtl/pgm_front.sv
module pgm_front (
  input  pgm_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   is_path_i,
  input  logic [7:0]             chr_i,
  input  logic                   present_i,
  input  logic                   first_i,
  input  logic                   last_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output pgm_pkg::item_t         q_item_o
);
  import pgm_pkg::*;

  logic [7:0] folded;

  // Lower ASCII letters when folding is on.
  always_comb begin
    folded = chr_i;
    if (cfg_i.case_fold && chr_i >= ChUpA && chr_i <= ChUpZ) begin
      folded = chr_i + CaseDiff;
    end
  end

  always_comb begin
    q_item_o.is_path = is_path_i;
    q_item_o.chr     = folded;
    q_item_o.present = present_i;
    q_item_o.first   = first_i;
    q_item_o.last    = last_i;
    q_item_o.sep     = (folded == ChSlash) || (folded == ChBslash);
    if (folded == ChStar) begin
      q_item_o.cls = KindStar;
    end else if (folded == ChQmark) begin
      q_item_o.cls = KindQmark;
    end else begin
      q_item_o.cls = KindLit;
    end
  end

  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

endmodule

// File: hw/rtl/pgm_fifo.sv
module pgm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  pgm_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output pgm_pkg::item_t rd_item_o
);
  import pgm_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// File: hw/rtl/pgm_back.sv
module pgm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pgm_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pgm_pkg::item_t in_item_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output pgm_pkg::res_t  res_o
);
  import pgm_pkg::*;

  // Token store: entries at or above the count are masked by vld_q.
  tok_kind_e             kind_q [PatternMax];
  logic [7:0]            byte_q [PatternMax];

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PatternMax-1:0] vld_q, vld_d;
  logic [NPos-1:0]       end_q, end_d;
  logic                  wild_q, wild_d;
  logic                  ovf_q, ovf_d;
  logic                  lstar_q, lstar_d;
  logic [NPos-1:0]       act_q, act_d;

  logic                  snap_vld_q;
  logic [NPos-1:0]       snap_act_q;
  logic [PatternMax-1:0] snap_p_q;
  logic [NPos-1:0]       snap_end_q;
  logic                  snap_mode_q;
  logic                  snap_ovf_q;
  logic                  out_vld_q;
  res_t                  out_q;

  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  tok_kind_e             wr_kind;
  logic [7:0]            wr_byte;

  logic [PatternMax-1:0] lit_hit, qm_m, star_m, glob_m, p_m;
  logic [NPos-1:0]       mask, closed, nxt;
  logic                  substr;
  logic                  fire, needs_res, snap_free, out_free;
  logic [NPos-1:0]       fin;

  always_comb begin
    for (int i = 0; i < PatternMax; i++) begin
      lit_hit[i] = vld_q[i] && (kind_q[i] == KindLit) && (byte_q[i] == in_item_i.chr);
      qm_m[i]    = vld_q[i] && (kind_q[i] == KindQmark);
      star_m[i]  = vld_q[i] && (kind_q[i] == KindStar);
      glob_m[i]  = vld_q[i] && (kind_q[i] == KindGlob);
    end
  end

  assign p_m    = star_m | glob_m;
  assign mask   = {vld_q, 1'b1};
  assign substr = cfg_i.search_mode && !wild_q;

  // One NFA step on the closed set.
  always_comb begin
    logic [NPos-1:0] base;
    base   = in_item_i.first ? NPos'(1) : act_q;
    closed = closure_f(base, p_m, cfg_i.search_mode) & mask;
    nxt    = {closed[PatternMax-1:0] &
              (lit_hit | (qm_m & {PatternMax{!in_item_i.sep}})), 1'b0}
           | {1'b0, closed[PatternMax-1:0] &
              (glob_m | (star_m & {PatternMax{!in_item_i.sep}}))}
           | (substr ? (closed & end_q) : '0);
    nxt    = nxt & mask;
    if (!in_item_i.present) begin
      nxt = base;
    end
  end

  assign out_free   = !out_vld_q || res_ready_i;
  assign snap_free  = !snap_vld_q || out_free;
  assign needs_res  = in_item_i.is_path && in_item_i.last;
  assign in_ready_o = !needs_res || snap_free;
  assign fire       = in_valid_i && in_ready_o;

  // Path: NFA step. Pattern: compact stars, append tokens, flag overflow.
  always_comb begin
    logic [CntW-1:0]       cnt_b;
    logic [PatternMax-1:0] vld_b;
    logic [NPos-1:0]       end_b;
    logic                  lstar_b, ovf_b, wild_b;
    logic                  app;
    cnt_b   = cnt_q;
    vld_b   = vld_q;
    end_b   = end_q;
    lstar_b = lstar_q;
    ovf_b   = ovf_q;
    wild_b  = wild_q;
    act_d   = act_q;
    wr_en   = 1'b0;
    wr_idx  = cnt_q[IdxW-1:0];
    wr_kind = in_item_i.cls;
    wr_byte = in_item_i.chr;
    app     = 1'b0;
    if (in_item_i.is_path) begin
      act_d = nxt;
    end else begin
      if (in_item_i.first) begin
        cnt_b   = '0;
        vld_b   = '0;
        end_b   = NPos'(1);
        lstar_b = 1'b0;
        ovf_b   = 1'b0;
        wild_b  = 1'b0;
        act_d   = NPos'(1);
      end
      if (in_item_i.present && !ovf_b) begin
        if (in_item_i.cls == KindStar || in_item_i.cls == KindQmark) begin
          wild_b = 1'b1;
        end
        if (in_item_i.cls == KindStar && lstar_b) begin
          wr_en   = 1'b1;
          wr_idx  = IdxW'(cnt_b - 1'b1);
          wr_kind = KindGlob;
          wr_byte = ChStar;
        end else begin
          app = 1'b1;
        end
      end
      if (app) begin
        if (vld_b[PatternMax-1]) begin
          ovf_b = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = cnt_b[IdxW-1:0];
          cnt_b   = cnt_b + 1'b1;
          vld_b   = {vld_b[PatternMax-2:0], 1'b1};
          end_b   = {end_b[NPos-2:0], 1'b0};
          lstar_b = (in_item_i.cls == KindStar);
        end
      end
    end
    cnt_d   = cnt_b;
    vld_d   = vld_b;
    end_d   = end_b;
    lstar_d = lstar_b;
    ovf_d   = ovf_b;
    wild_d  = wild_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      vld_q   <= '0;
      end_q   <= NPos'(1);
      wild_q  <= 1'b0;
      ovf_q   <= 1'b0;
      lstar_q <= 1'b0;
      act_q   <= NPos'(1);
    end else if (fire) begin
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      end_q   <= end_d;
      wild_q  <= wild_d;
      ovf_q   <= ovf_d;
      lstar_q <= lstar_d;
      act_q   <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      kind_q[wr_idx] <= wr_kind;
      byte_q[wr_idx] <= wr_byte;
    end
  end

  // Result stage: hold what the final closure needs, then close and pick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
    end else if (snap_free) begin
      snap_vld_q <= fire && needs_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && needs_res) begin
      snap_act_q  <= act_d;
      snap_p_q    <= p_m;
      snap_end_q  <= end_q;
      snap_mode_q <= cfg_i.search_mode;
      snap_ovf_q  <= ovf_q;
    end
  end

  assign fin = closure_f(snap_act_q, snap_p_q, snap_mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= snap_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_vld_q) begin
      out_q.matched  <= |(fin & snap_end_q);
      out_q.overflow <= snap_ovf_q;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: hw/rtl/path_glob_matcher_core.sv
// Result path: a path beat with tlast gives one result beat through the FIFO, the
// snapshot and output registers; pattern beats and other path beats give none.
// Throughput: one beat per cycle unless results stall; NFA step is combinational.
// Reset (rst_ni low, asynchronous): empty pattern, no overflow, only position zero
// active, search_mode 0, case_fold 1; the token store needs no clearing pass.
module path_glob_matcher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pgm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic                           cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] byte_value, [8] byte_present, [9] first_byte, [15:10] zero
  input  logic [pgm_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] mode (0 pattern byte, 1 path byte)
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] matched, [1] pattern_overflow, [7:2] zero
  output logic [pgm_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import pgm_pkg::*;

  cfg_t  cfg_q;
  logic  q_wr_valid, q_wr_ready;
  item_t q_wr_item;
  logic  q_rd_valid, q_rd_ready;
  item_t q_rd_item;
  res_t  res;

  // Config must be written only while idle, unchecked here; always take the beat.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.search_mode <= 1'b0;
      cfg_q.case_fold   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSearchMode: cfg_q.search_mode <= cfg_data_i;
        CfgCaseFold:   cfg_q.case_fold   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: fold the byte and classify it as a token kind.
  pgm_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .is_path_i  (s_axis_tuser_i),
    .chr_i      (s_axis_tdata_i[7:0]),
    .present_i  (s_axis_tdata_i[8]),
    .first_i    (s_axis_tdata_i[9]),
    .last_i     (s_axis_tlast_i),
    .q_valid_o  (q_wr_valid),
    .q_ready_i  (q_wr_ready),
    .q_item_o   (q_wr_item)
  );

  // Decouple the input side from back-end stalls.
  pgm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (q_wr_valid),
    .wr_ready_o (q_wr_ready),
    .wr_item_i  (q_wr_item),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_item_o  (q_rd_item)
  );

  // Back end: token store, NFA state and the result register.
  pgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (q_rd_valid),
    .in_ready_o  (q_rd_ready),
    .in_item_i   (q_rd_item),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {{(OutDataW - 2){1'b0}}, res.overflow, res.matched};

endmodule

// File: hw/rtl/pgm_checker.sv
module pgm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tuser_i,
  input logic                         s_axis_tlast_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [pgm_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import pgm_pkg::*;

  logic [3:0] pend_q;
  logic       in_last, out_beat;

  assign in_last  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i && s_axis_tlast_i;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // Count results still owed for accepted last path beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {3'b0, in_last} - {3'b0, out_beat};
    end
  end

  // Reset seen at one edge leaves the result side quiet at the next.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pend_q != '0)
    else $error("result without a last path beat");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataW-1:2] == '0)
    else $error("result padding not zero");

endmodule

bind path_glob_matcher_core pgm_checker u_pgm_checker (.*);
